>>> src/irt_pkg.sv
package irt_pkg;

  // Table size; the index and counter widths follow from it, the comparison width in part.
  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the stream words.
  localparam int ACTION_W   = 2;
  localparam int SLOT_W     = 6;
  localparam int ID_W       = 32;
  localparam int HEARD_W    = 16;
  localparam int PAYLOAD_W  = 64;
  localparam int STATUS_W   = 3;
  localparam int OUT_SLOT_W = 5;
  localparam int OUT_CNT_W  = 6;

  localparam int CMP_W      = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int IN_BITS    = SLOT_W + ID_W + HEARD_W + PAYLOAD_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = STATUS_W + 2 * OUT_SLOT_W + OUT_CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_FIND   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BEYOND   = 3'd1,
    ST_GAP      = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [HEARD_W-1:0]   heard;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    action_t           action;
    logic [SLOT_W-1:0] slot;
    entry_t            entry;
  } request_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // apply insert, latch the outcome, restart the scan
    logic scan;   // walk the occupied slots
    logic emit;   // load the result register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_stat_t;

  // Slot numbers leave the block masked or zero-extended to the result field.
  function automatic logic [OUT_SLOT_W-1:0] to_out_slot(input logic [IDX_W-1:0] v);
    logic [IDX_W+OUT_SLOT_W-1:0] w;
    w = {{OUT_SLOT_W{1'b0}}, v};
    return w[OUT_SLOT_W-1:0];
  endfunction

  function automatic logic [OUT_CNT_W-1:0] to_out_count(input logic [CNT_W-1:0] v);
    logic [CNT_W+OUT_CNT_W-1:0] w;
    w = {{OUT_CNT_W{1'b0}}, v};
    return w[OUT_CNT_W-1:0];
  endfunction

endpackage

>>> src/irt_ctrl.sv
module irt_ctrl import irt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        // The last read is folded in during the cycle that sees the end.
        if (stat.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/irt_datapath.sv
module irt_datapath import irt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  request_t              req_in,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [OUT_DATA_W-1:0] out_data
);

  request_t             req;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_after;
  logic [CNT_W-1:0]     scan_ptr;
  entry_t               mem [CAPACITY];
  entry_t               rd_data;
  logic                 rd_en;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_idx;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;
  logic [CMP_W-1:0]     tgt;
  logic [CMP_W-1:0]     count_ext;
  logic [CMP_W-1:0]     slot_ext;
  logic [CMP_W-1:0]     k_ext;
  logic                 err;
  status_t              err_code;
  logic                 do_write;
  logic                 rm_ok;
  logic                 err_q;
  status_t              err_code_q;
  logic                 rm_q;
  logic                 is_find;
  logic                 skip;
  logic                 shift;
  logic [IDX_W-1:0]     new_idx;
  logic                 have_min;
  logic [HEARD_W-1:0]   best_heard;
  logic [IDX_W-1:0]     min_slot;
  logic                 found_hit;
  logic [IDX_W-1:0]     found_slot;
  status_t              status;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_in;
    end
  end

  assign count_ext = CMP_W'(count);
  assign slot_ext  = CMP_W'(req.slot);
  assign tgt       = (req.action == ACT_APPEND) ? count_ext : slot_ext;
  assign is_find   = (req.action == ACT_FIND);

  always_comb begin
    err      = 1'b0;
    err_code = ST_OK;
    do_write = 1'b0;
    rm_ok    = 1'b0;
    unique case (req.action) inside
      ACT_INSERT, ACT_APPEND: begin
        if (tgt >= CMP_W'(CAPACITY)) begin
          err      = 1'b1;
          err_code = ST_BEYOND;
        end else if (tgt > count_ext) begin
          err      = 1'b1;
          err_code = ST_GAP;
        end else begin
          do_write = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (slot_ext >= count_ext) begin
          err      = 1'b1;
          err_code = ST_EMPTY;
        end else begin
          rm_ok = 1'b1;
        end
      end
      ACT_FIND: begin
      end
      default: begin
      end
    endcase
  end

  // The outcome is frozen here: an append changes the count it was judged on.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      err_q      <= err;
      err_code_q <= err_code;
      rm_q       <= rm_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec && do_write && (tgt == count_ext)) begin
      count <= count + CNT_W'(1);
    end else if (cmd.emit && rm_q) begin
      count <= count - CNT_W'(1);
    end
  end

  assign stat.scan_done = (scan_ptr >= count);
  assign rd_en          = cmd.scan && !stat.scan_done;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      scan_ptr <= '0;
    end else if (rd_en) begin
      scan_ptr <= scan_ptr + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_ptr[IDX_W-1:0];
  end

  // Removal walks the old table: the removed slot is skipped and every later
  // entry is written one slot lower as it goes past.
  assign k_ext   = CMP_W'(rd_idx);
  assign skip    = rm_q && (k_ext == slot_ext);
  assign shift   = rm_q && (k_ext > slot_ext);
  assign new_idx = shift ? (rd_idx - IDX_W'(1)) : rd_idx;

  assign wr_en   = (cmd.exec && do_write) || (rd_valid && shift);
  assign wr_addr = cmd.exec ? tgt[IDX_W-1:0] : new_idx;
  assign wr_data = cmd.exec ? req.entry : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[scan_ptr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      have_min   <= 1'b0;
      min_slot   <= '0;
      found_hit  <= 1'b0;
      found_slot <= '0;
    end else if (rd_valid) begin
      if (!skip && (!have_min || (rd_data.heard < best_heard))) begin
        have_min   <= 1'b1;
        best_heard <= rd_data.heard;
        min_slot   <= new_idx;
      end
      if (is_find && !found_hit && (rd_data.id == req.entry.id)) begin
        found_hit  <= 1'b1;
        found_slot <= rd_idx;
      end
    end
  end

  always_comb begin
    if (err_q) begin
      status = err_code_q;
    end else if (is_find && !found_hit) begin
      status = ST_NOTFOUND;
    end else begin
      status = ST_OK;
    end
  end

  assign count_after   = rm_q ? (count - CNT_W'(1)) : count;
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= OUT_DATA_W'({to_out_count(count_after), to_out_slot(min_slot),
                               to_out_slot(found_slot), status});
    end
  end

endmodule

>>> src/indexed_record_table.sv
// Channel   Dir  Word                                              Accepted when
// s_        in   tuser: action; tdata: slot, id, heard, payload    s_tvalid && s_tready
// m_        out  tdata: status, found slot, least-heard slot, count m_tvalid && m_tready
//
// Every word passes through accept, execute, scan and result load; the scan walks
// the occupied slots, whose number is the count after an insert and before a
// remove. The scan reads one table entry per cycle through the single read port
// of the record memory.
// Reset clears the count, the control state and the read and output valid flags;
// the record memory is never cleared, as only slots below the count are ever read.
// A new word is taken while an earlier result waits in the output register;
// the block then holds its finished result until that register is free.
module indexed_record_table import irt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // From bit 0: slot_index[5:0], record_id[31:0], record_heard[15:0],
  // record_payload[63:0], zero fill.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // From bit 0: action[1:0].
  input  logic [ACTION_W-1:0]   s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // From bit 0: status[2:0], found_slot[4:0], least_heard_slot[4:0],
  // entry_count[5:0], zero fill.
  output logic [OUT_DATA_W-1:0] m_tdata
);

  request_t req_in;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Unpack the incoming word into the request record.
  assign req_in.action        = action_t'(s_tuser);
  assign req_in.slot          = s_tdata[SLOT_W-1:0];
  assign req_in.entry.id      = s_tdata[SLOT_W +: ID_W];
  assign req_in.entry.heard   = s_tdata[SLOT_W + ID_W +: HEARD_W];
  assign req_in.entry.payload = s_tdata[SLOT_W + ID_W + HEARD_W +: PAYLOAD_W];

  // The controller sequences accept, execute, scan and result load.
  irt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the record memory, the count, the scan pipeline
  // with its minimum and match trackers, and the output register.
  irt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_in    (req_in),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

`ifndef NO_ASSERTIONS
  // A word is never followed by another in the very next cycle.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again straight after a word");

  // A result is only loaded into a free output register.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result loaded over one still waiting");

  // Loading a result returns the controller to accepting input.
  a_emit_then_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (s_tready && m_tvalid))
    else $error("controller not idle after a result");

  // The scan only runs between an accepted word and its result.
  a_scan_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !s_tready)
    else $error("scan running while input is open");
`endif

endmodule

>>> tb/indexed_record_table_tb.sv
module indexed_record_table_tb;
  import irt_pkg::*;

  // One operation as it is sent to the table.
  typedef struct {
    action_t               act;
    logic [SLOT_W-1:0]     slot;
    logic [ID_W-1:0]       id;
    logic [HEARD_W-1:0]    heard;
    logic [PAYLOAD_W-1:0]  payload;
  } table_op_t;

  // The reply word that each operation produces, split into its fields.
  typedef struct {
    status_t                status;
    logic [OUT_SLOT_W-1:0]  found;
    logic [OUT_SLOT_W-1:0]  least;
    logic [OUT_CNT_W-1:0]   count;
  } table_reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [ACTION_W-1:0]   s_tuser = ACT_INSERT;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  indexed_record_table DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // Operations still to be sent, and the replies that accepted ones are owed.
  table_op_t    ops_to_send[$];
  table_reply_t awaited_replies[$];
  int           failures = 0;

  // Shadow copy of the table. Payloads never reach a reply, so only ids and
  // times-heard counts are kept. Slots at or above the count are never read.
  logic [ID_W-1:0]    shadow_id[CAPACITY];
  logic [HEARD_W-1:0] shadow_heard[CAPACITY];
  int                 shadow_count = 0;

  // Count as the stimulus generator sees it, so that it can steer the table
  // towards full and back towards empty.
  int                 planned_count = 0;

  // Applies one operation to the shadow table and returns the reply that the
  // block must give for it.
  function automatic table_reply_t apply_table_op(table_op_t op);
    table_reply_t r;
    int target;
    int i;
    r.status = ST_OK;
    r.found  = '0;
    case (op.act)
      ACT_INSERT, ACT_APPEND: begin
        target = (op.act == ACT_APPEND) ? shadow_count : int'(op.slot);
        if (target >= CAPACITY) begin
          r.status = ST_BEYOND;
        end else if (target > shadow_count) begin
          r.status = ST_GAP;
        end else begin
          shadow_id[target]    = op.id;
          shadow_heard[target] = op.heard;
          if (target == shadow_count) shadow_count++;
        end
      end
      ACT_REMOVE: begin
        if (int'(op.slot) >= shadow_count) begin
          r.status = ST_EMPTY;
        end else begin
          // Later records close the gap, one slot down each.
          for (i = int'(op.slot) + 1; i < shadow_count; i++) begin
            shadow_id[i-1]    = shadow_id[i];
            shadow_heard[i-1] = shadow_heard[i];
          end
          shadow_count--;
        end
      end
      default: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_id[i] == op.id) begin
            r.status = ST_OK;
            r.found  = i[OUT_SLOT_W-1:0];
            break;
          end
        end
      end
    endcase
    // The first slot with the lowest count wins a tie; an empty table gives 0.
    target = 0;
    for (i = 1; i < shadow_count; i++) begin
      if (shadow_heard[i] < shadow_heard[target]) target = i;
    end
    r.least = target[OUT_SLOT_W-1:0];
    r.count = shadow_count[OUT_CNT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, logic [7:0] got);
    if (got !== want[7:0]) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  // Queues an operation and keeps the generator's view of the count in step.
  task automatic queue_op(action_t act, int slot, logic [ID_W-1:0] id,
                          logic [HEARD_W-1:0] heard, logic [PAYLOAD_W-1:0] payload);
    table_op_t op;
    op.act     = act;
    op.slot    = slot[SLOT_W-1:0];
    op.id      = id;
    op.heard   = heard;
    op.payload = payload;
    ops_to_send.push_back(op);
    case (act)
      ACT_INSERT: if (slot < CAPACITY && slot == planned_count) planned_count++;
      ACT_APPEND: if (planned_count < CAPACITY) planned_count++;
      ACT_REMOVE: if (slot < planned_count) planned_count--;
      default: ;
    endcase
  endtask

  // Ids are mostly drawn from a small pool so that finds hit and duplicate ids
  // appear; the rest are fully random so that every bit of the field moves.
  function automatic logic [ID_W-1:0] pick_record_id();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1, 2:    return $urandom_range(0, 11);
      default: return 32'hFFFF_FFF0 | $urandom_range(0, 11);
    endcase
  endfunction

  // Small counts give plenty of ties for the least-heard slot.
  function automatic logic [HEARD_W-1:0] pick_heard();
    if ($urandom_range(0, 1) == 0) return HEARD_W'($urandom_range(0, 7));
    return HEARD_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [PAYLOAD_W-1:0] pick_payload();
    return {$urandom, $urandom};
  endfunction

  // Sender. Words go out in bursts of random length; the gaps between bursts
  // are mostly short but now and then longer than the block's slowest word,
  // so that fresh words land on every stage of the scan. The expected reply is
  // worked out at the edge where the word is accepted.
  int        burst_left = 1;
  int        gap_left = 0;
  table_op_t word_on_bus;

  always @(posedge clk) begin : sender
    logic send_next;
    send_next = 1'b0;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) awaited_replies.push_back(apply_table_op(word_on_bus));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (ops_to_send.size() > 0) begin
          send_next = 1'b1;
        end
        if (send_next) begin
          word_on_bus = ops_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= word_on_bus.act;
          s_tdata  <= {{(IN_DATA_W - IN_BITS){1'b0}}, word_on_bus.payload,
                       word_on_bus.heard, word_on_bus.id, word_on_bus.slot};
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 45)
                                                   : $urandom_range(0, 4);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Its back-pressure comes in moods: no stalls at all, occasional
  // short stalls, or frequent long ones that leave a finished result waiting
  // while the next word is already taken.
  int stall_left = 0;
  int mood_left = 0;
  int stall_mood = 0;

  always @(posedge clk) begin : receiver
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (mood_left == 0) begin
        stall_mood = $urandom_range(0, 3);
        mood_left = $urandom_range(50, 300);
      end else begin
        mood_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (stall_mood != 0 && $urandom_range(0, 7) < stall_mood) begin
        stall_left = $urandom_range(0, (stall_mood == 3) ? 40 : 6);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Checker. Each reply word is matched against the oldest awaited reply.
  always @(posedge clk) begin : reply_checker
    table_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: reply word %h arrived with none awaited, expected nothing",
                 $time, m_tdata);
        failures++;
      end else begin
        want = awaited_replies.pop_front();
        check_field("status", 32'(want.status), 8'(m_tdata[STATUS_W-1:0]));
        check_field("found_slot", 32'(want.found), 8'(m_tdata[STATUS_W +: OUT_SLOT_W]));
        check_field("least_heard_slot", 32'(want.least),
                    8'(m_tdata[STATUS_W + OUT_SLOT_W +: OUT_SLOT_W]));
        check_field("entry_count", 32'(want.count),
                    8'(m_tdata[STATUS_W + 2 * OUT_SLOT_W +: OUT_CNT_W]));
      end
    end
  end

  initial begin : stimulus
    int pick;
    logic filling;
    filling = 1'b1;

    // Directed opening: errors on an empty table, then a small table built
    // up with overwrites, duplicate ids and tied counts, and taken apart again.
    queue_op(ACT_FIND,   0,  32'h0,         16'h0,    64'h0);  // miss on empty
    queue_op(ACT_REMOVE, 0,  32'h0,         16'h0,    64'h0);  // slot empty
    queue_op(ACT_REMOVE, 63, 32'h0,         16'h0,    64'h0);  // far past capacity
    queue_op(ACT_INSERT, 1,  32'h1,         16'h1,    64'h1);  // gap past end
    queue_op(ACT_INSERT, 63, 32'h1,         16'h1,    64'h1);  // beyond capacity
    queue_op(ACT_INSERT, CAPACITY, 32'h1,   16'h1,    64'h1);  // just at capacity
    queue_op(ACT_INSERT, 0,  32'hFFFF_FFFF, 16'hFFFF, '1);
    queue_op(ACT_APPEND, 0,  32'h0,         16'h0,    64'h0);
    queue_op(ACT_APPEND, 0,  32'h5,         16'h0,    pick_payload());  // tied minimum
    queue_op(ACT_INSERT, 4,  32'h7,         16'd100,  pick_payload());  // gap past end
    queue_op(ACT_INSERT, 3,  32'h7,         16'd100,  pick_payload());  // grows the table
    queue_op(ACT_INSERT, 1,  32'h9,         16'd200,  pick_payload());  // overwrite
    queue_op(ACT_FIND,   0,  32'h5,         16'h0,    64'h0);
    queue_op(ACT_FIND,   0,  32'hFFFF_FFFF, 16'h0,    64'h0);
    queue_op(ACT_FIND,   0,  32'h1234_5678, 16'h0,    64'h0);
    queue_op(ACT_INSERT, 0,  32'h5,         16'd50,   pick_payload());  // duplicate id
    queue_op(ACT_FIND,   0,  32'h5,         16'h0,    64'h0);  // first match wins
    queue_op(ACT_REMOVE, 3,  32'h0,         16'h0,    64'h0);  // last slot
    queue_op(ACT_REMOVE, 3,  32'h0,         16'h0,    64'h0);  // slot equal to count
    queue_op(ACT_REMOVE, 0,  32'h0,         16'h0,    64'h0);  // shifts the rest
    queue_op(ACT_REMOVE, 40, 32'h0,         16'h0,    64'h0);
    queue_op(ACT_FIND,   0,  32'h9,         16'h0,    64'h0);
    queue_op(ACT_REMOVE, 1,  32'h0,         16'h0,    64'h0);
    queue_op(ACT_REMOVE, 0,  32'h0,         16'h0,    64'h0);
    queue_op(ACT_FIND,   0,  32'h9,         16'h0,    64'h0);  // miss on empty again

    // Random part. The table is driven up to full, held there for a while so
    // that appends and inserts at the end fail, and then drained to empty, over
    // and over. About one word in ten is noise with a slot from the whole field.
    for (int n = 0; n < 650; n++) begin
      if (planned_count == CAPACITY && $urandom_range(0, 5) == 0) filling = 1'b0;
      else if (planned_count == 0) filling = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        case ($urandom_range(0, 2))
          0: queue_op(ACT_INSERT, $urandom_range(0, 63), pick_record_id(), pick_heard(),
                      pick_payload());
          1: queue_op(ACT_REMOVE, $urandom_range(0, 63), $urandom,
                      HEARD_W'($urandom_range(0, 65535)), pick_payload());
          default: queue_op(ACT_FIND, $urandom_range(0, 63), $urandom,
                            HEARD_W'($urandom_range(0, 65535)), pick_payload());
        endcase
      end else if (pick < 20) begin
        queue_op(ACT_FIND, $urandom_range(0, 63), pick_record_id(), pick_heard(),
                 pick_payload());
      end else if (filling ? (pick < 70) : (pick >= 75 && pick < 85)) begin
        queue_op(ACT_APPEND, $urandom_range(0, 63), pick_record_id(), pick_heard(),
                 pick_payload());
      end else if (filling ? (pick < 90) : (pick >= 85)) begin
        // Overwrite an occupied slot or write the one just past the end.
        queue_op(ACT_INSERT, $urandom_range(0, planned_count), pick_record_id(),
                 pick_heard(), pick_payload());
      end else begin
        queue_op(ACT_REMOVE, $urandom_range(0, (planned_count > 0) ? planned_count - 1 : 0),
                 pick_record_id(), pick_heard(), pick_payload());
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (ops_to_send.size() > 0 || s_tvalid || awaited_replies.size() > 0)
      @(posedge clk);
    // A stray extra reply would take at most one full scan to show up.
    repeat (CAPACITY + 10) @(posedge clk);

    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin : watchdog
    #(12 * 600000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
